/* rtl/hbef_pkg.sv */
// Package for the harmonic bond energy/force pipeline.
// Holds shared constants, register indexes and the status code type.
// No dependencies.
`default_nettype none

package hbef_pkg;

    localparam int unsigned COORD_WIDTH    = 32;
    localparam int unsigned DISP_BITS      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int unsigned NUM_BASE_SITES = 2;

    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned IN_DATA_W = 288;
    localparam int unsigned OUT_DATA_W = 128;

    localparam logic [CFG_IDX_W-1:0] REG_SPRING_AA = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING_AB = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING_BA = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING_BB = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REST_AA   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REST_AB   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REST_BA   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REST_BB   = 4'd7;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

endpackage

`default_nettype wire

/* rtl/harmonic_bond_energy_force.sv */
// Harmonic bond energy and force, fully pipelined, one bond image per cycle unless stalled.
// Depends on hbef_pkg.
//
// Usage:
//   s_axis: one bond image per item. tdata carries to, from and shift
//   coordinates; tuser carries the two sub-lattice indexes.
//   m_axis: one result per item, energy and force in tdata, status in tuser.
//   cfg: write channel for the eight spring/rest registers, always ready;
//   the user must write only while no item is in flight; the block has no check for this.
// Pipeline: 4 setup stages, 32 square-root stages, 5 multiply stages,
//   32 divide stages and the output register.
// Throughput: one item per cycle when not stalled, with the square root
//   and divider pipelines producing one bit per stage.
// Reset: clears the config registers, the valid chain and the output and skid
//   valid flags; the block then accepts items immediately.
// Stall: a skid register behind the output register absorbs one result;
//   while it is full the pipeline holds and s_axis_tready is low.
`default_nettype none

module harmonic_bond_energy_force #(
    parameter int unsigned COORD_WIDTH    = hbef_pkg::COORD_WIDTH,
    parameter int unsigned NUM_BASE_SITES = hbef_pkg::NUM_BASE_SITES
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // to_x, to_y, to_z, from_x, from_y, from_z, shift_x, shift_y, shift_z
    input  wire logic [hbef_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    // to_sublattice, from_sublattice
    input  wire logic [1:0]                             s_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // bond_energy, force_x, force_y, force_z
    output logic [hbef_pkg::OUT_DATA_W-1:0]             m_axis_tdata,
    // status
    output logic [1:0]                                  m_axis_tuser,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [hbef_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [31:0]                            i_cfg_data
);

    localparam int SQ_STG = 32;
    localparam int DV_STG = 32;
    localparam int NSTG   = 4 + SQ_STG + 5 + DV_STG;

    localparam int unsigned DISP_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    localparam logic signed [33:0] DMAX = 34'sd2 ** (DISP_BITS - 1) - 34'sd1;
    localparam logic signed [33:0] DMIN = -DMAX - 34'sd1;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [2:0]       pos;
        logic             sat;
        logic [1:0]       pair;
    } t_side;

    typedef struct packed {
        hbef_pkg::t_status status;
        logic [31:0]       fz;
        logic [31:0]       fy;
        logic [31:0]       fx;
        logic [31:0]       energy;
    } t_res;

    logic en;
    logic [NSTG-1:0] r_vld;

    // configuration
    logic [31:0] r_spring [4];
    logic [31:0] r_rest   [4];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_spring[i] <= '0;
                r_rest[i]   <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hbef_pkg::REG_SPRING_AA: r_spring[0] <= i_cfg_data;
                hbef_pkg::REG_SPRING_AB: r_spring[1] <= i_cfg_data;
                hbef_pkg::REG_SPRING_BA: r_spring[2] <= i_cfg_data;
                hbef_pkg::REG_SPRING_BB: r_spring[3] <= i_cfg_data;
                hbef_pkg::REG_REST_AA:   r_rest[0]   <= i_cfg_data;
                hbef_pkg::REG_REST_AB:   r_rest[1]   <= i_cfg_data;
                hbef_pkg::REG_REST_BA:   r_rest[2]   <= i_cfg_data;
                hbef_pkg::REG_REST_BB:   r_rest[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], s_axis_tvalid};
        end
    end

    // P1: raw displacement
    logic signed [33:0] r_p1_diff [3];
    logic [1:0]         r_p1_pair;
    logic               to_sub;
    logic               from_sub;

    assign to_sub   = (NUM_BASE_SITES > 1) ? s_axis_tuser[0] : 1'b0;
    assign from_sub = (NUM_BASE_SITES > 1) ? s_axis_tuser[1] : 1'b0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p1_diff[i] <=
                    {{2{s_axis_tdata[32*i+31]}}, s_axis_tdata[32*i +: 32]}
                  - {{2{s_axis_tdata[32*(i+3)+31]}}, s_axis_tdata[32*(i+3) +: 32]}
                  - {{2{s_axis_tdata[32*(i+6)+31]}}, s_axis_tdata[32*(i+6) +: 32]};
            end
            r_p1_pair <= {to_sub, from_sub};
        end
    end

    // P2: clamp and magnitude
    t_side r_p2_side;
    t_side n_p2_side;

    always_comb begin
        logic signed [33:0] v;
        logic signed [33:0] m;
        n_p2_side      = '0;
        n_p2_side.pair = r_p1_pair;
        for (int i = 0; i < 3; i++) begin
            v = r_p1_diff[i];
            if (v > DMAX) begin
                v = DMAX;
                n_p2_side.sat = 1'b1;
            end
            if (v < DMIN) begin
                v = DMIN;
                n_p2_side.sat = 1'b1;
            end
            m = v[33] ? -v : v;
            n_p2_side.mag[i] = m[31:0];
            n_p2_side.neg[i] = v[33];
            n_p2_side.pos[i] = !v[33] && (v != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_side <= n_p2_side;
        end
    end

    // P3: squares
    t_side       r_p3_side;
    logic [63:0] r_p3_sq [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_side <= r_p2_side;
            for (int i = 0; i < 3; i++) begin
                r_p3_sq[i] <= 64'(r_p2_side.mag[i]) * 64'(r_p2_side.mag[i]);
            end
        end
    end

    // P4: sum of squares
    t_side       r_p4_side;
    logic [63:0] r_p4_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_side <= r_p3_side;
            r_p4_sum  <= r_p3_sq[0] + r_p3_sq[1] + r_p3_sq[2];
        end
    end

    // square root, one result bit per stage
    logic [63:0] r_sq_v    [SQ_STG];
    logic [32:0] r_sq_rem  [SQ_STG];
    logic [31:0] r_sq_root [SQ_STG];
    t_side       r_sq_side [SQ_STG];

    for (genvar g = 0; g < SQ_STG; g++) begin : g_sqrt
        localparam int J = SQ_STG - 1 - g;
        logic [63:0] w_v;
        logic [32:0] w_rem;
        logic [31:0] w_root;
        t_side       w_side;
        logic [34:0] w_x;
        logic [34:0] w_t;

        if (g == 0) begin : g_first
            assign w_v    = r_p4_sum;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_side = r_p4_side;
        end else begin : g_next
            assign w_v    = r_sq_v[g-1];
            assign w_rem  = r_sq_rem[g-1];
            assign w_root = r_sq_root[g-1];
            assign w_side = r_sq_side[g-1];
        end

        assign w_x = {w_rem, w_v[2*J+1 -: 2]};
        assign w_t = {1'b0, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_v[g]    <= w_v;
                r_sq_side[g] <= w_side;
                if (w_x >= w_t) begin
                    r_sq_rem[g]  <= 33'(w_x - w_t);
                    r_sq_root[g] <= {w_root[30:0], 1'b1};
                end else begin
                    r_sq_rem[g]  <= w_x[32:0];
                    r_sq_root[g] <= {w_root[30:0], 1'b0};
                end
            end
        end
    end

    // Q1: delta against rest length
    t_side       r_q1_side;
    logic [31:0] r_q1_len;
    logic [31:0] r_q1_dmag;
    logic [31:0] r_q1_k;
    logic        r_q1_dneg;
    logic        r_q1_dpos;
    logic        r_q1_lenz;
    logic [32:0] q1_delta;
    logic [32:0] q1_dabs;

    assign q1_delta = {1'b0, r_sq_root[SQ_STG-1]} - {1'b0, r_rest[r_sq_side[SQ_STG-1].pair]};
    assign q1_dabs  = q1_delta[32] ? -q1_delta : q1_delta;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_side <= r_sq_side[SQ_STG-1];
            r_q1_len  <= r_sq_root[SQ_STG-1];
            r_q1_k    <= r_spring[r_sq_side[SQ_STG-1].pair];
            r_q1_dmag <= q1_dabs[31:0];
            r_q1_dneg <= q1_delta[32];
            r_q1_dpos <= !q1_delta[32] && (q1_delta != '0);
            r_q1_lenz <= (r_sq_root[SQ_STG-1] == '0);
        end
    end

    // Q2: delta squared and k*|delta|
    t_side       r_q2_side;
    logic [31:0] r_q2_len;
    logic [31:0] r_q2_k;
    logic [63:0] r_q2_dsq;
    logic [63:0] r_q2_kd;
    logic        r_q2_dneg;
    logic        r_q2_dpos;
    logic        r_q2_lenz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q2_side <= r_q1_side;
            r_q2_len  <= r_q1_len;
            r_q2_k    <= r_q1_k;
            r_q2_dsq  <= 64'(r_q1_dmag) * 64'(r_q1_dmag);
            r_q2_kd   <= 64'(r_q1_k) * 64'(r_q1_dmag);
            r_q2_dneg <= r_q1_dneg;
            r_q2_dpos <= r_q1_dpos;
            r_q2_lenz <= r_q1_lenz;
        end
    end

    // Q3: partial products
    t_side       r_q3_side;
    logic [31:0] r_q3_len;
    logic [63:0] r_q3_elo;
    logic [63:0] r_q3_ehi;
    logic [63:0] r_q3_flo [3];
    logic [63:0] r_q3_fhi [3];
    logic        r_q3_dneg;
    logic        r_q3_dpos;
    logic        r_q3_lenz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q3_side <= r_q2_side;
            r_q3_len  <= r_q2_len;
            r_q3_elo  <= 64'(r_q2_k) * 64'(r_q2_dsq[31:0]);
            r_q3_ehi  <= 64'(r_q2_k) * 64'(r_q2_dsq[63:32]);
            for (int i = 0; i < 3; i++) begin
                r_q3_flo[i] <= 64'(r_q2_kd[31:0]) * 64'(r_q2_side.mag[i]);
                r_q3_fhi[i] <= 64'(r_q2_kd[63:32]) * 64'(r_q2_side.mag[i]);
            end
            r_q3_dneg <= r_q2_dneg;
            r_q3_dpos <= r_q2_dpos;
            r_q3_lenz <= r_q2_lenz;
        end
    end

    // Q4: product sums, energy, force signs
    logic [95:0] q4_eprod;
    logic        q4_esat;
    logic [95:0] q4_num [3];

    always_comb begin
        q4_eprod = {32'd0, r_q3_elo} + {r_q3_ehi, 32'd0};
        q4_esat  = (q4_eprod[95:65] != '0);
        for (int i = 0; i < 3; i++) begin
            q4_num[i] = {32'd0, r_q3_flo[i]} + {r_q3_fhi[i], 32'd0};
        end
    end

    logic [31:0] r_q4_energy;
    logic        r_q4_sat;
    logic [95:0] r_q4_num [3];
    logic [47:0] r_q4_den;
    logic [2:0]  r_q4_fneg;
    logic        r_q4_lenz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q4_energy <= q4_esat ? 32'hFFFF_FFFF : q4_eprod[64:33];
            r_q4_sat    <= r_q3_side.sat | q4_esat;
            for (int i = 0; i < 3; i++) begin
                r_q4_num[i]  <= q4_num[i];
                r_q4_fneg[i] <= (r_q3_dpos && r_q3_side.pos[i])
                             || (r_q3_dneg && r_q3_side.neg[i]);
            end
            r_q4_den  <= {r_q3_len, 16'd0};
            r_q4_lenz <= r_q3_lenz;
        end
    end

    // Q5: quotient overflow check and divider setup
    logic [2:0][47:0] r_q5_rem;
    logic [2:0][31:0] r_q5_low;
    logic [2:0]       r_q5_ovf;
    logic [47:0]      r_q5_den;
    logic [31:0]      r_q5_energy;
    logic             r_q5_sat;
    logic [2:0]       r_q5_fneg;
    logic             r_q5_lenz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_q5_ovf[i] <= (r_q4_num[i][95:32] >= {16'd0, r_q4_den});
                r_q5_rem[i] <= r_q4_num[i][79:32];
                r_q5_low[i] <= r_q4_num[i][31:0];
            end
            r_q5_den    <= r_q4_den;
            r_q5_energy <= r_q4_energy;
            r_q5_sat    <= r_q4_sat;
            r_q5_fneg   <= r_q4_fneg;
            r_q5_lenz   <= r_q4_lenz;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [2:0][47:0] r_dv_rem    [DV_STG];
    logic [2:0][31:0] r_dv_low    [DV_STG];
    logic [2:0][31:0] r_dv_q      [DV_STG];
    logic [2:0]       r_dv_ovf    [DV_STG];
    logic [47:0]      r_dv_den    [DV_STG];
    logic [31:0]      r_dv_energy [DV_STG];
    logic             r_dv_sat    [DV_STG];
    logic [2:0]       r_dv_fneg   [DV_STG];
    logic             r_dv_lenz   [DV_STG];

    for (genvar g = 0; g < DV_STG; g++) begin : g_div
        localparam int B = DV_STG - 1 - g;
        logic [2:0][47:0] w_rem;
        logic [2:0][31:0] w_low;
        logic [2:0][31:0] w_q;
        logic [2:0]       w_ovf;
        logic [47:0]      w_den;
        logic [31:0]      w_energy;
        logic             w_sat;
        logic [2:0]       w_fneg;
        logic             w_lenz;
        logic [2:0][47:0] n_rem;
        logic [2:0][31:0] n_q;

        if (g == 0) begin : g_first
            assign w_rem    = r_q5_rem;
            assign w_low    = r_q5_low;
            assign w_q      = '0;
            assign w_ovf    = r_q5_ovf;
            assign w_den    = r_q5_den;
            assign w_energy = r_q5_energy;
            assign w_sat    = r_q5_sat;
            assign w_fneg   = r_q5_fneg;
            assign w_lenz   = r_q5_lenz;
        end else begin : g_next
            assign w_rem    = r_dv_rem[g-1];
            assign w_low    = r_dv_low[g-1];
            assign w_q      = r_dv_q[g-1];
            assign w_ovf    = r_dv_ovf[g-1];
            assign w_den    = r_dv_den[g-1];
            assign w_energy = r_dv_energy[g-1];
            assign w_sat    = r_dv_sat[g-1];
            assign w_fneg   = r_dv_fneg[g-1];
            assign w_lenz   = r_dv_lenz[g-1];
        end

        always_comb begin
            logic [48:0] x;
            logic        take;
            for (int a = 0; a < 3; a++) begin
                x    = {w_rem[a], w_low[a][B]};
                take = (x >= {1'b0, w_den});
                n_rem[a] = take ? 48'(x - {1'b0, w_den}) : x[47:0];
                n_q[a]   = {w_q[a][30:0], take};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[g]    <= n_rem;
                r_dv_q[g]      <= n_q;
                r_dv_low[g]    <= w_low;
                r_dv_ovf[g]    <= w_ovf;
                r_dv_den[g]    <= w_den;
                r_dv_energy[g] <= w_energy;
                r_dv_sat[g]    <= w_sat;
                r_dv_fneg[g]   <= w_fneg;
                r_dv_lenz[g]   <= w_lenz;
            end
        end
    end

    // result: force clamp, sign, status
    t_res n_res;

    always_comb begin
        logic [31:0] lim;
        logic [31:0] q;
        logic        fs;
        logic        any_sat;
        logic [2:0][31:0] f;
        any_sat = r_dv_sat[DV_STG-1];
        for (int i = 0; i < 3; i++) begin
            lim = r_dv_fneg[DV_STG-1][i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            q   = r_dv_q[DV_STG-1][i];
            fs  = r_dv_ovf[DV_STG-1][i] || (q > lim);
            if (fs) begin
                q = lim;
            end
            any_sat = any_sat | fs;
            f[i] = r_dv_fneg[DV_STG-1][i] ? -q : q;
        end
        n_res.energy = r_dv_energy[DV_STG-1];
        if (r_dv_lenz[DV_STG-1]) begin
            n_res.fx     = '0;
            n_res.fy     = '0;
            n_res.fz     = '0;
            n_res.status = hbef_pkg::ST_ZERO;
        end else begin
            n_res.fx     = f[0];
            n_res.fy     = f[1];
            n_res.fz     = f[2];
            n_res.status = any_sat ? hbef_pkg::ST_SAT : hbef_pkg::ST_OK;
        end
    end

    // output register and skid
    logic r_out_vld;
    t_res r_out;
    logic r_skd_vld;
    t_res r_skd;

    assign en = !r_skd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            if (m_axis_tready) begin
                r_out     <= r_skd;
                r_skd_vld <= 1'b0;
            end
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_vld <= r_vld[NSTG-1];
            r_out     <= n_res;
        end else if (r_vld[NSTG-1]) begin
            r_skd_vld <= 1'b1;
            r_skd     <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.fz, r_out.fy, r_out.fx, r_out.energy};
    assign m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire

/* rtl/hbef_chk.sv */
// Port-level checker for harmonic_bond_energy_force, bound to the top level.
// Depends on hbef_pkg.
`default_nettype none

module hbef_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [hbef_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire logic [1:0]                        m_axis_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == hbef_pkg::ST_ZERO)
            |-> (m_axis_tdata[127:32] == '0))
        else $error("zero-length bond with nonzero force");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("not ready after reset");

endmodule

bind harmonic_bond_energy_force hbef_chk u_hbef_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* verif/tb_harmonic_bond_energy_force.sv */
// Self-checking testbench for harmonic_bond_energy_force: random and directed
// bond images, energy/force predicted in fixed point and checked per item.
// Depends on hbef_pkg and the RTL top level.
`default_nettype none

class bond_scoreboard;
    logic [127:0] exp_data[$];
    logic [1:0]   exp_status[$];
    int           errors;

    function new();
        errors = 0;
    endfunction

    function void note_item(logic [127:0] d, logic [1:0] s);
        exp_data.push_back(d);
        exp_status.push_back(s);
    endfunction

    function void check_result(logic [127:0] d, logic [1:0] s);
        logic [127:0] ed;
        logic [1:0]   es;
        if (exp_data.size() == 0) begin
            $display("%0t: unexpected result data=%h status=%0d", $time, d, s);
            errors++;
            return;
        end
        ed = exp_data.pop_front();
        es = exp_status.pop_front();
        for (int f = 0; f < 4; f++) begin
            if (ed[32*f +: 32] !== d[32*f +: 32]) begin
                $display("%0t: field %0d expected %h actual %h", $time, f,
                         ed[32*f +: 32], d[32*f +: 32]);
                errors++;
            end
        end
        if (es !== s) begin
            $display("%0t: status expected %0d actual %0d", $time, es, s);
            errors++;
        end
    endfunction
endclass

module tb_harmonic_bond_energy_force;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 74;
    localparam longint CYCLE_LIMIT = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [hbef_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [hbef_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [hbef_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    harmonic_bond_energy_force dut (.*);

    always #6 i_clk = ~i_clk;

    bond_scoreboard sb = new();
    logic [31:0] spring_k[4];
    logic [31:0] rest_len[4];
    longint cycles = 0;
    bit rx_quiet = 0;

    // floor(n/d) capped at cap; n up to 128 bits
    function automatic logic [63:0] div_capped(logic [127:0] n, logic [127:0] d,
                                               logic [63:0] cap, ref bit sat);
        logic [127:0] q;
        q = n / d;
        if (q > {64'd0, cap}) begin
            sat = 1;
            return cap;
        end
        return q[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    task automatic predict_bond(logic [hbef_pkg::IN_DATA_W-1:0] d, logic [1:0] u);
        longint r[3];
        logic [63:0] mag[3];
        logic [63:0] sum, len, dmag;
        logic [127:0] prod;
        logic [31:0] res[4];
        longint delta;
        logic [31:0] k;
        int pair;
        bit sat;
        bit neg;
        logic [63:0] q;
        hbef_pkg::t_status st;
        sat = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            r[i] = longint'($signed(d[32*i +: 32]))
                 - (longint'($signed(d[32*(3+i) +: 32]))
                 + longint'($signed(d[32*(6+i) +: 32])));
            if (r[i] > 64'sd2147483647) begin
                r[i] = 64'sd2147483647;
                sat = 1;
            end
            if (r[i] < -64'sd2147483648) begin
                r[i] = -64'sd2147483648;
                sat = 1;
            end
            mag[i] = r[i] < 0 ? -r[i] : r[i];
            sum += mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        pair = u[0] * 2 + u[1];
        k = spring_k[pair];
        delta = longint'(len) - longint'({32'd0, rest_len[pair]});
        dmag = delta < 0 ? -delta : delta;
        prod = {96'd0, k} * {64'd0, dmag * dmag};
        if (prod[127:65] != 0) begin
            res[0] = 32'hFFFF_FFFF;
            sat = 1;
        end else begin
            res[0] = prod[64:33];
        end
        if (len == 0) begin
            res[1] = 0;
            res[2] = 0;
            res[3] = 0;
            st = hbef_pkg::ST_ZERO;
        end else begin
            for (int i = 0; i < 3; i++) begin
                neg = (delta > 0 && r[i] > 0) || (delta < 0 && r[i] < 0);
                prod = {64'd0, 64'(k * dmag)} * {64'd0, mag[i]};
                q = div_capped(prod, {48'd0, len, 16'd0},
                               neg ? 64'h8000_0000 : 64'h7FFF_FFFF, sat);
                res[1+i] = neg ? -q[31:0] : q[31:0];
            end
            st = sat ? hbef_pkg::ST_SAT : hbef_pkg::ST_OK;
        end
        sb.note_item({res[3], res[2], res[1], res[0]}, st);
    endtask

    task automatic write_reg(logic [hbef_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx < 4) spring_k[idx] = val;
        else if (idx < 8) rest_len[idx-4] = val;
        @(posedge i_clk);
    endtask

    // valid stays high between back-to-back items and drops only before a gap
    task automatic send_bond(logic [hbef_pkg::IN_DATA_W-1:0] d, logic [1:0] u, bit gaps);
        int g;
        g = gaps ? $urandom_range(0, 7) : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= u;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_bond(d, u);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_data.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0008_0000))
                          - 32'sh0004_0000);
            default: return 32'($signed($urandom_range(0, 32'h0200_0000))
                                - 32'sh0100_0000);
        endcase
    endfunction

    task automatic random_bond(int mode, bit gaps);
        logic [hbef_pkg::IN_DATA_W-1:0] d;
        for (int i = 0; i < 9; i++) d[32*i +: 32] = rand_coord(mode);
        // occasional coincident sites give zero-length bonds
        if ($urandom_range(0, 19) == 0)
            for (int i = 0; i < 3; i++)
                d[32*i +: 32] = d[32*(3+i) +: 32] + d[32*(6+i) +: 32];
        send_bond(d, 2'($urandom()), gaps);
    endtask

    function automatic logic [hbef_pkg::IN_DATA_W-1:0] pack_xyz(logic [31:0] t,
                                                               logic [31:0] f,
                                                               logic [31:0] s);
        return {{3{s}}, {3{f}}, {3{t}}};
    endfunction

    // receiver with random stalls
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("harmonic_bond_energy_force regression: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] edges[6];
        for (int i = 0; i < 4; i++) begin
            spring_k[i] = 0;
            rest_len[i] = 0;
        end
        edges = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h0001_0000};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, then unit springs
        send_bond(pack_xyz(32'h0001_0000, 0, 0), 2'b00, 0);
        drain();
        for (int i = 0; i < 8; i++)
            write_reg(hbef_pkg::CFG_IDX_W'(i), i < 4 ? 32'h0001_0000 : 32'h0000_8000);
        write_reg(4'd8, 32'hDEAD_BEEF);
        write_reg(4'd15, 32'h1234_5678);
        for (int a = 0; a < 6; a++)
            send_bond(pack_xyz(edges[a], edges[(a+2)%6], edges[(a+4)%6]),
                      2'(a), 0);
        send_bond(pack_xyz(32'h0003_0000, 32'h0001_0000, 32'h0002_0000), 2'b11, 0);
        send_bond({96'd0, 96'd0, 32'd0, 32'd0, 32'h0002_0000}, 2'b01, 0);
        send_bond({96'd0, 96'd0, 32'd0, 32'd0, 32'hFFFE_0000}, 2'b10, 0);
        send_bond({96'd0, 96'd0, 32'h0000_4000, 32'd0, 32'd0}, 2'b00, 0);
        send_bond({{6{32'h8000_0000}}, {3{32'h7FFF_FFFF}}}, 2'b11, 0);
        send_bond({{3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}},
                  2'b00, 0);
        send_bond({288{1'b1}}, 2'b11, 0);
        drain();

        // phases over several register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 8; i++) begin
                case (ph)
                    0: write_reg(hbef_pkg::CFG_IDX_W'(i), 32'hFFFF_FFFF);
                    1: write_reg(hbef_pkg::CFG_IDX_W'(i), 32'h0);
                    2: write_reg(hbef_pkg::CFG_IDX_W'(i),
                                 i < 4 ? 32'h0000_0100 : 32'h0001_0000);
                    3: write_reg(hbef_pkg::CFG_IDX_W'(i), $urandom());
                    default: write_reg(hbef_pkg::CFG_IDX_W'(i),
                        i < 4 ? $urandom_range(0, 32'h0010_0000)
                              : $urandom_range(0, 32'h0080_0000));
                endcase
            end
            for (int n = 0; n < 220; n++)
                random_bond($urandom_range(0, 2), ph != 2);
            if (ph == 3) begin
                rx_quiet = 1;
                drain();
                rx_quiet = 0;
            end else begin
                drain();
            end
        end
        drain();
        if (sb.errors == 0)
            $display("harmonic_bond_energy_force regression: pass");
        else
            $display("harmonic_bond_energy_force regression: fail");
        $finish;
    end
endmodule

`default_nettype wire

/* files.f */
rtl/hbef_pkg.sv
rtl/harmonic_bond_energy_force.sv
rtl/hbef_chk.sv
verif/tb_harmonic_bond_energy_force.sv
